// ----- sv/stm_pkg.sv -----
// shared types and constants for the scrolling text marquee
package stm_pkg;

    localparam int MAX_CHARS   = 32;
    localparam int SCREEN_SIZE = 8;
    localparam int GLYPH_COLS  = 5;
    localparam int CHAR_PITCH  = 6;
    localparam int STORE_DEPTH = MAX_CHARS * GLYPH_COLS;
    localparam int ROW_BITS    = 7;

    localparam int OP_W        = 2;
    localparam int ADDR_W      = 8;
    localparam int POS_W       = 3;
    localparam int LEVEL_W     = 8;
    localparam int CHARS_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int SCROLL_W    = 10;
    localparam int CH_W        = 6;

    // number of text columns fetched per frame (one more than the screen width)
    localparam int TAPS        = SCREEN_SIZE + 1;
    localparam int TAP_CNT_W   = 4;

    // floor(col / 6) == (col * 171) >> 10 for col below 256
    localparam int RECIP_MUL   = 171;
    localparam int RECIP_SHIFT = 10;

    localparam int SCROLL_MIN  = -(2 * CHAR_PITCH * MAX_CHARS);

    localparam logic [CHARS_W-1:0] TEXT_CHARS_RST = CHARS_W'(31);
    localparam logic [LEVEL_W-1:0] PEAK_RST       = LEVEL_W'(70);
    localparam logic [LEVEL_W-1:0] START_RST      = LEVEL_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_RENDER = 2'd1,
        OP_WRITE  = 2'd2,
        OP_NONE   = 2'd3
    } stm_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_CHARS = 2'd0,
        CFG_PEAK_LEVEL = 2'd1,
        CFG_START_POS  = 2'd2,
        CFG_UNUSED     = 2'd3
    } stm_cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_READ,
        S_FETCH,
        S_EMIT
    } stm_state_t;

endpackage

// ----- sv/stm_if.sv -----
// channel interfaces: command transactions in, pixel transactions out
interface stm_cmd_if;
    import stm_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [ADDR_W-1:0]   glyph_index;
    logic [ROW_BITS-1:0] glyph_bits;

    modport source (output valid, output op, output glyph_index, output glyph_bits,
                    input ready);
    modport sink   (input valid, input op, input glyph_index, input glyph_bits,
                    output ready);
endinterface

interface stm_pix_if;
    import stm_pkg::*;

    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   pixel_row;
    logic [POS_W-1:0]   pixel_column;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] red_level;
    logic               frame_last;

    modport source (output valid, output pixel_row, output pixel_column,
                    output green_level, output red_level, output frame_last,
                    input ready);
    modport sink   (input valid, input pixel_row, input pixel_column,
                    input green_level, input red_level, input frame_last,
                    output ready);
endinterface

// ----- sv/scrolling_text_marquee.sv -----
// scrolling text marquee for an 8x8 led matrix with half-column blending
//
//   channel   dir   handshake     payload
//   cmd       in    valid/ready   op, glyph_index, glyph_bits
//   pix       out   valid/ready   pixel_row, pixel_column, green_level, red_level,
//                                 frame_last
//   cfg       in    cfg_we        cfg_index, cfg_data
//
// tick, glyph write and unused op leave the block idle, ready for the next command
// render fetches 9 text columns, each through S_ADDR, S_READ and S_FETCH in the
// shared column address unit and the glyph store read port, then emits 64 pixel
// transactions at one per cycle when pix.ready stays high
// cmd.ready is high only while idle; a stalled pixel holds its payload
// reset clears control and configuration; the glyph store is not cleared
module scrolling_text_marquee (
    input  logic                            clk,
    input  logic                            rst_n,
    stm_cmd_if.sink                         cmd,
    stm_pix_if.source                       pix,
    input  logic                            cfg_we,
    input  logic [stm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import stm_pkg::*;

    stm_state_t state_reg, state_next;

    logic [CHARS_W-1:0]         text_chars_reg;
    logic [LEVEL_W-1:0]         peak_reg;
    logic [LEVEL_W-1:0]         start_reg;
    logic signed [SCROLL_W-1:0] scroll_reg, scroll_next;
    logic signed [SCROLL_W-1:0] col_reg, col_next;
    logic [CH_W-1:0]            ch_reg;
    logic [TAP_CNT_W-1:0]       cnt_reg;
    logic                       half_reg;
    logic                       rd_valid_reg;
    logic [ROW_BITS-1:0]        rd_data_reg;
    logic [ROW_BITS-1:0]        taps_reg [TAPS];
    logic [POS_W-1:0]           x_reg;
    logic [POS_W-1:0]           y_reg;

    logic [ROW_BITS-1:0]        glyph_mem [STORE_DEPTH];

    logic                       cmd_fire;
    logic                       pix_fire;
    logic                       last_pixel;
    logic [CHARS_W-1:0]         chars;
    logic [8:0]                 width;
    logic [9:0]                 limit;
    logic signed [SCROLL_W-1:0] scroll_dec;
    logic [11:0]                wrap_sum;
    logic signed [SCROLL_W:0]   neg_scroll;
    logic [15:0]                recip_prod;
    logic [7:0]                 cc_wide;
    logic [2:0]                 cc;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       col_live;
    logic                       bl;
    logic                       br;
    logic [LEVEL_W-1:0]         half_peak;
    logic [LEVEL_W-1:0]         quarter_peak;
    logic [LEVEL_W:0]           red_sum;
    logic [LEVEL_W:0]           green_sum;
    logic [ROW_BITS:0]          tap0_ext;
    logic [ROW_BITS:0]          tap1_ext;

    assign cmd_fire   = cmd.valid && cmd.ready;
    assign pix_fire   = pix.valid && pix.ready;
    assign last_pixel = (x_reg == POS_W'(SCREEN_SIZE - 1)) &&
                        (y_reg == POS_W'(SCREEN_SIZE - 1));

    assign chars = (text_chars_reg > CHARS_W'(MAX_CHARS)) ? CHARS_W'(MAX_CHARS)
                                                          : text_chars_reg;
    assign width = 9'(chars) * 9'(CHAR_PITCH);
    assign limit = 10'(chars) * 10'(2 * CHAR_PITCH);

    // tick: step left, wrap once the text is past the left edge
    assign scroll_dec = scroll_reg - SCROLL_W'(1);
    assign wrap_sum   = {{2{scroll_dec[SCROLL_W-1]}}, scroll_dec} + {2'b00, limit};

    always_comb
    begin
        scroll_next = scroll_reg;
        if (cmd_fire && (cmd.op == OP_TICK))
        begin
            if (wrap_sum[11])
            begin
                scroll_next = $signed({2'b00, start_reg});
            end
            else
            begin
                scroll_next = scroll_dec;
            end
        end
    end

    // first text column seen by screen column 0 is floor(-p / 2)
    assign neg_scroll = -$signed({scroll_reg[SCROLL_W-1], scroll_reg});

    always_comb
    begin
        col_next = col_reg;
        if (cmd_fire && (cmd.op == OP_RENDER))
        begin
            col_next = SCROLL_W'(neg_scroll >>> 1);
        end
        else if (state_reg == S_FETCH)
        begin
            col_next = col_reg + SCROLL_W'(1);
        end
    end

    // shared column address unit: character by reciprocal, then column in character
    assign recip_prod = 16'(col_reg[7:0]) * 16'(RECIP_MUL);
    assign cc_wide    = col_reg[7:0] - 8'(ch_reg) * 8'(CHAR_PITCH);
    assign cc         = cc_wide[2:0];
    assign rd_addr    = ADDR_W'(ch_reg) * ADDR_W'(GLYPH_COLS) + ADDR_W'(cc);
    assign col_live   = !col_reg[SCROLL_W-1] && (col_reg[8:0] < width) &&
                        (cc < 3'(GLYPH_COLS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire && (cmd.op == OP_RENDER))
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (cnt_reg == TAP_CNT_W'(TAPS - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_EMIT:
            begin
                if (pix_fire && last_pixel)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    assign tap0_ext     = {1'b0, taps_reg[0]};
    assign tap1_ext     = {1'b0, taps_reg[1]};
    assign half_peak    = peak_reg >> 1;
    assign quarter_peak = peak_reg >> 2;

    always_comb
    begin
        cmd.ready = (state_reg == S_IDLE);
        pix.valid = (state_reg == S_EMIT);
        bl        = tap0_ext[y_reg];
        br        = tap1_ext[y_reg];
        if (half_reg)
        begin
            red_sum   = (bl ? {1'b0, half_peak} : '0) + (br ? {1'b0, half_peak} : '0);
            green_sum = (bl ? {1'b0, quarter_peak} : '0) +
                        (br ? {1'b0, quarter_peak} : '0);
        end
        else
        begin
            red_sum   = bl ? {1'b0, peak_reg} : '0;
            green_sum = bl ? {1'b0, half_peak} : '0;
        end
        pix.pixel_row    = y_reg;
        pix.pixel_column = x_reg;
        pix.red_level    = (red_sum > {1'b0, peak_reg}) ? peak_reg : red_sum[LEVEL_W-1:0];
        pix.green_level  = (green_sum > {1'b0, peak_reg}) ? peak_reg
                                                          : green_sum[LEVEL_W-1:0];
        pix.frame_last   = last_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            text_chars_reg <= TEXT_CHARS_RST;
            peak_reg       <= PEAK_RST;
            start_reg      <= START_RST;
            scroll_reg     <= $signed({2'b00, START_RST});
            cnt_reg        <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            scroll_reg <= scroll_next;
            if (cfg_we)
            begin
                case (stm_cfg_t'(cfg_index))
                    CFG_TEXT_CHARS: text_chars_reg <= cfg_data[CHARS_W-1:0];
                    CFG_PEAK_LEVEL: peak_reg       <= cfg_data;
                    CFG_START_POS:  start_reg      <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd_fire && (cmd.op == OP_RENDER))
            begin
                cnt_reg <= '0;
                x_reg   <= '0;
                y_reg   <= '0;
            end
            else if (state_reg == S_FETCH)
            begin
                cnt_reg <= cnt_reg + TAP_CNT_W'(1);
            end
            else if (pix_fire)
            begin
                x_reg <= x_reg + POS_W'(1);
                if (x_reg == POS_W'(SCREEN_SIZE - 1))
                begin
                    y_reg <= y_reg + POS_W'(1);
                end
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        if (cmd_fire && (cmd.op == OP_RENDER))
        begin
            half_reg <= scroll_reg[0];
        end
        if (state_reg == S_ADDR)
        begin
            ch_reg <= recip_prod[RECIP_SHIFT +: CH_W];
        end
        if (state_reg == S_READ)
        begin
            rd_valid_reg <= col_live;
        end
        if (state_reg == S_FETCH)
        begin
            for (int i = 0; i < TAPS - 1; i++)
            begin
                taps_reg[i] <= taps_reg[i + 1];
            end
            taps_reg[TAPS - 1] <= rd_valid_reg ? rd_data_reg : '0;
        end
        else if (pix_fire)
        begin
            // circular shift; an extra place at row end brings column 0 back to the front
            for (int i = 0; i < TAPS; i++)
            begin
                if (x_reg == POS_W'(SCREEN_SIZE - 1))
                begin
                    taps_reg[i] <= taps_reg[(i + 2) % TAPS];
                end
                else
                begin
                    taps_reg[i] <= taps_reg[(i + 1) % TAPS];
                end
            end
        end
    end

    // glyph store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd_fire && (cmd.op == OP_WRITE) &&
            (cmd.glyph_index < ADDR_W'(STORE_DEPTH)))
        begin
            glyph_mem[cmd.glyph_index] <= cmd.glyph_bits;
        end
        if ((state_reg == S_READ) && col_live)
        begin
            rd_data_reg <= glyph_mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid |-> !cmd.ready)
        else $error("pixel valid while command channel ready");

    a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && (cmd.op == OP_RENDER)) |=> (state_reg == S_ADDR))
        else $error("render transaction did not start the fetch");

    a_first_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix.valid) |-> ((x_reg == '0) && (y_reg == '0)))
        else $error("frame did not start at row 0 column 0");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready && pix.frame_last) |=> cmd.ready)
        else $error("block not idle after last pixel");

    a_scroll_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($signed(scroll_reg) >= SCROLL_MIN) && ($signed(scroll_reg) <= 255))
        else $error("scroll position out of range");
`endif

endmodule
